/* design/pdf_pkg.sv */
// Package for the packet duplicate filter: payload types, codes and constants.
// No dependencies.
`default_nettype none
package pdf_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
    localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

    localparam logic [1:0] OpStart = 2'd0;
    localparam logic [1:0] OpData  = 2'd1;
    localparam logic [1:0] OpClaim = 2'd2;

    localparam logic [1:0] OcRejected = 2'd0;
    localparam logic [1:0] OcDuplicate = 2'd1;
    localparam logic [1:0] OcMerged = 2'd2;
    localparam logic [1:0] OcNew = 2'd3;

    localparam logic RegWindow = 1'b0;
    localparam logic RegMaxEntries = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] source_length;
        logic [7:0]  data_byte;
        logic [7:0]  destination_mask;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic       granted;
        logic [1:0] outcome;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item
        logic mix;        // one hash byte step (xor+multiply)
        logic seed;       // reset hash to basis
        logic scan_step;  // examine entry r_rd, compact
        logic commit;     // finish claim: insert/merge, latch result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic [1:0] operation;
        logic       mask_zero;
        logic       mul_done;
    } t_sts;
endpackage
`default_nettype wire

/* design/pdf_datapath.sv */
// Datapath: FNV-1a hash with a 4-step 16-bit-chunked multiplier and the entry table.
// Depends on pdf_pkg.
`default_nettype none
module pdf_datapath
    import pdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in         i_item,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_window_ms,
    input  wire logic [4:0]  i_max_entries,
    output t_sts             o_sts,
    output t_out             o_result
);
    t_in r_item;
    logic [63:0] r_hash, r_acc, r_x;
    logic [1:0] r_part;
    logic r_mul_busy, r_second;

    // hash multiply: x * prime split into four 16-bit partial products
    logic [63:0] n_partial;
    always_comb begin
        n_partial = 64'(r_x * {48'd0, FnvPrime[15:0]} ) ;
        unique case (r_part)
            2'd0: n_partial = r_x * 64'(FnvPrime[15:0]);
            2'd1: n_partial = (r_x * 64'(FnvPrime[31:16])) << 16;
            2'd2: n_partial = (r_x * 64'(FnvPrime[47:32])) << 32;
            2'd3: n_partial = (r_x * 64'(FnvPrime[63:48])) << 48;
            default: n_partial = '0;
        endcase
    end

    // table storage
    logic [63:0] r_fp [TableDepth];
    logic [31:0] r_seen [TableDepth];
    logic [7:0]  r_dest [TableDepth];
    logic [CntW-1:0] r_count, r_rd, r_wr;
    logic r_matched;
    logic [IdxW-1:0] r_midx;
    t_out r_res;

    logic [IdxW-1:0] rd_i;
    logic [31:0] age;
    logic keep, hit;
    logic [CntW-1:0] limit;
    assign rd_i = r_rd[IdxW-1:0];
    assign age = r_item.now_ms - r_seen[rd_i];
    assign keep = (age <= i_window_ms);
    assign hit = keep && !r_matched && (r_fp[rd_i] == r_hash);
    assign limit = (i_max_entries > 5'(TableDepth)) ? CntW'(TableDepth)
                                                    : CntW'(i_max_entries);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hash <= FnvBasis;
            r_mul_busy <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_item <= i_item;
                r_rd <= '0;
                r_wr <= '0;
                r_matched <= 1'b0;
                r_second <= 1'b0;
            end
            if (i_cmd.seed) r_hash <= FnvBasis;
            if (i_cmd.mix && !r_mul_busy) begin
                unique case (r_item.operation)
                    OpStart: r_x <= (i_cmd.seed ? FnvBasis : r_hash) ^ 64'(
                                  r_second ? r_item.source_length[7:0]
                                           : r_item.source_length[15:8]);
                    default: r_x <= r_hash ^ 64'(r_item.data_byte);
                endcase
                r_part <= 2'd0;
                r_acc <= '0;
                r_mul_busy <= 1'b1;
            end else if (r_mul_busy) begin
                r_acc <= r_acc + n_partial;
                r_part <= r_part + 2'd1;
                if (r_part == 2'd3) begin
                    r_hash <= r_acc + n_partial;
                    r_mul_busy <= 1'b0;
                    r_second <= 1'b1;
                end
            end
            if (i_cmd.scan_step) begin
                if (keep) begin
                    r_fp[r_wr[IdxW-1:0]] <= r_fp[rd_i];
                    r_seen[r_wr[IdxW-1:0]] <= r_seen[rd_i];
                    r_dest[r_wr[IdxW-1:0]] <= r_dest[rd_i];
                    r_wr <= r_wr + 1'b1;
                end
                if (hit) begin
                    r_matched <= 1'b1;
                    r_midx <= r_wr[IdxW-1:0];
                end
                r_rd <= r_rd + 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_item.destination_mask == 8'd0) begin
                    r_res <= '{1'b0, OcRejected};
                end else if (r_matched) begin
                    r_count <= r_wr;
                    if ((r_dest[r_midx] & r_item.destination_mask) != 8'd0) begin
                        r_res <= '{1'b0, OcDuplicate};
                    end else begin
                        r_dest[r_midx] <= r_dest[r_midx] | r_item.destination_mask;
                        r_res <= '{1'b1, OcMerged};
                    end
                end else if (limit == '0) begin
                    r_count <= r_wr;
                    r_res <= '{1'b0, OcRejected};
                end else if (r_wr >= limit && r_wr != '0) begin
                    r_count <= r_wr;
                    r_res <= '{1'b1, OcNew};
                    // evict oldest: shift down, append at the top
                    for (int k = 0; k < TableDepth - 1; k++) begin
                        if (CntW'(k + 1) < r_wr) begin
                            r_fp[k] <= r_fp[k+1];
                            r_seen[k] <= r_seen[k+1];
                            r_dest[k] <= r_dest[k+1];
                        end
                    end
                    r_fp[IdxW'(r_wr - 1'b1)] <= r_hash;
                    r_seen[IdxW'(r_wr - 1'b1)] <= r_item.now_ms;
                    r_dest[IdxW'(r_wr - 1'b1)] <= r_item.destination_mask;
                end else begin
                    r_res <= '{1'b1, OcNew};
                    r_fp[r_wr[IdxW-1:0]] <= r_hash;
                    r_seen[r_wr[IdxW-1:0]] <= r_item.now_ms;
                    r_dest[r_wr[IdxW-1:0]] <= r_item.destination_mask;
                    r_count <= r_wr + 1'b1;
                end
            end
        end
    end

    assign o_sts.scan_done = (r_rd >= r_count);
    assign o_sts.operation = r_item.operation;
    assign o_sts.mask_zero = (r_item.destination_mask == 8'd0);
    assign o_sts.mul_done = !r_mul_busy;
    assign o_result = r_res;
endmodule
`default_nettype wire

/* design/pdf_ctrl.sv */
// Controller state machine sequencing hash steps and table scans.
// Depends on pdf_pkg.
`default_nettype none
module pdf_ctrl
    import pdf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_MIX1, S_MIX2, S_SCAN, S_COMMIT, S_OUT
    } t_state;
    t_state r_state;
    logic r_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        unique case (r_state)
            S_DECODE: begin
                if (i_sts.operation == OpStart) begin
                    o_cmd.seed = 1'b1;
                    o_cmd.mix = 1'b1;
                end else if (i_sts.operation == OpData) begin
                    o_cmd.mix = 1'b1;
                end
            end
            S_MIX1: o_cmd.mix = i_sts.mul_done && (i_sts.operation == OpStart);
            S_SCAN: o_cmd.scan_step = !i_sts.scan_done && !i_sts.mask_zero;
            // result register must be free before it is overwritten
            S_COMMIT: o_cmd.commit = !r_valid;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    if (i_sts.operation == OpClaim) r_state <= S_SCAN;
                    else if (i_sts.operation == OpStart || i_sts.operation == OpData)
                        r_state <= S_MIX1;
                    else r_state <= S_IDLE;
                end
                S_MIX1: if (i_sts.mul_done)
                    r_state <= (i_sts.operation == OpStart) ? S_MIX2 : S_IDLE;
                S_MIX2: if (i_sts.mul_done) r_state <= S_IDLE;
                S_SCAN: if (i_sts.scan_done || i_sts.mask_zero) r_state <= S_COMMIT;
                S_COMMIT: if (!r_valid) r_state <= S_OUT;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/packet_duplicate_filter.sv */
// Top level of the packet duplicate filter: registers, controller and datapath.
// Depends on pdf_pkg, pdf_ctrl, pdf_datapath.
`default_nettype none
// A start beat hashes two bytes, each through a four-step 16-bit-sliced
// multiply; a data beat hashes one byte; a claim with a nonempty mask runs
// the entry-by-entry expiry scan, one step per stored entry, before its commit.
// A claim yields one result beat; start and data beats yield none. A waiting
// result does not block input; only a later claim holds at its commit step
// until the earlier result has been taken.
module packet_duplicate_filter
    import pdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    logic [31:0] r_window_ms;
    logic [4:0]  r_max_entries;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= 32'd30000;
            r_max_entries <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegWindow: r_window_ms <= i_cfg_data;
                RegMaxEntries: r_max_entries <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    pdf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    pdf_datapath u_dp (
        .i_clk, .i_rst_n, .i_item(i_data), .i_cmd(cmd),
        .i_window_ms(r_window_ms), .i_max_entries(r_max_entries),
        .o_sts(sts), .o_result(o_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_ready}))
        else $error("handshake output unknown");
    a_nogrant_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.outcome == OcRejected || o_data.outcome == OcDuplicate)
        |-> !o_data.granted)
        else $error("grant on refused claim");
endmodule
`default_nettype wire

/* tb/sv/packet_duplicate_filter_tb.sv */
// Testbench for packet_duplicate_filter: drives start, data and claim beats, predicts
// the claim outcome with a local fingerprint table and checks every result beat.
// Depends on pdf_pkg and packet_duplicate_filter.
`default_nettype none
module packet_duplicate_filter_tb;
    import pdf_pkg::*;

    // operation code with no meaning; the block ignores it
    localparam logic [1:0] OpUnused = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    packet_duplicate_filter dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] win_ms;
    logic [4:0]  max_ent;
    logic [63:0] fp_hash;
    logic [63:0] tab_fp [TableDepth];
    logic [31:0] tab_seen [TableDepth];
    logic [7:0]  tab_dst [TableDepth];
    int          tab_cnt;

    t_out        verdicts_due [$];
    int          n_errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
        return (h ^ {56'd0, b}) * FnvPrime;
    endfunction

    function automatic t_out predict_claim(logic [7:0] mask, logic [31:0] now);
        t_out r;
        int   kept;
        int   lim;
        bit   hit;
        r = '{granted: 1'b0, outcome: OcRejected};
        kept = 0;
        hit = 1'b0;
        if (mask == 8'd0) return r;
        for (int i = 0; i < tab_cnt; i++) begin
            if (now - tab_seen[i] > win_ms) continue;
            tab_fp[kept] = tab_fp[i];
            tab_seen[kept] = tab_seen[i];
            tab_dst[kept] = tab_dst[i];
            kept++;
        end
        tab_cnt = kept;
        for (int i = 0; i < tab_cnt && !hit; i++) begin
            if (tab_fp[i] == fp_hash) begin
                hit = 1'b1;
                if ((tab_dst[i] & mask) != 0) begin
                    r.outcome = OcDuplicate;
                end else begin
                    tab_dst[i] |= mask;
                    r = '{granted: 1'b1, outcome: OcMerged};
                end
            end
        end
        if (!hit) begin
            lim = (max_ent > TableDepth) ? TableDepth : max_ent;
            if (lim != 0) begin
                if (tab_cnt >= lim && tab_cnt > 0) begin
                    for (int i = 1; i < tab_cnt; i++) begin
                        tab_fp[i-1] = tab_fp[i];
                        tab_seen[i-1] = tab_seen[i];
                        tab_dst[i-1] = tab_dst[i];
                    end
                    tab_cnt--;
                end
                if (tab_cnt < TableDepth) begin
                    tab_fp[tab_cnt] = fp_hash;
                    tab_seen[tab_cnt] = now;
                    tab_dst[tab_cnt] = mask;
                    tab_cnt++;
                end
                r = '{granted: 1'b1, outcome: OcNew};
            end
        end
        return r;
    endfunction

    // valid stays up between beats unless the sender idles; drain() drops it
    task automatic send_beat(t_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (beat.operation)
            OpStart: begin
                fp_hash = fnv_mix(fnv_mix(FnvBasis, beat.source_length[15:8]),
                                  beat.source_length[7:0]);
            end
            OpData: fp_hash = fnv_mix(fp_hash, beat.data_byte);
            OpClaim: begin
                verdicts_due = {verdicts_due,
                                predict_claim(beat.destination_mask, beat.now_ms)};
            end
            default: ;
        endcase
    endtask

    function automatic t_in mk(logic [1:0] op, logic [15:0] len, logic [7:0] b,
                               logic [7:0] mask, logic [31:0] now);
        t_in t;
        t = '{operation: op, source_length: len, data_byte: b,
              destination_mask: mask, now_ms: now};
        return t;
    endfunction

    task automatic send_packet(logic [15:0] len, int nbytes, logic [7:0] mask,
                               logic [31:0] now);
        send_beat(mk(OpStart, len, 8'($urandom), 8'($urandom), $urandom));
        for (int i = 0; i < nbytes; i++)
            send_beat(mk(OpData, 16'($urandom),
                         $urandom_range(3) == 0 ? 8'(i) : 8'($urandom),
                         8'($urandom), $urandom));
        send_beat(mk(OpClaim, 16'($urandom), 8'($urandom), mask, now));
    endtask

    // wait until all predicted results are taken and the block is idle
    task automatic drain();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegWindow) win_ms = val;
        else max_ent = val[4:0];
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (verdicts_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result beat %p", o_data);
                end else begin
                    t_out want;
                    want = verdicts_due.pop_front();
                    if (o_data.granted !== want.granted || o_data.outcome !== want.outcome) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch: expected granted=%0d outcome=%0d, ",
                                      "got granted=%0d outcome=%0d"},
                                     want.granted, want.outcome, o_data.granted, o_data.outcome);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        // extremes of the length field, all ops, empty mask, code three
        send_packet(16'h0000, 0, 8'h01, 32'd0);
        send_packet(16'h0000, 0, 8'h01, 32'd5);      // duplicate
        send_packet(16'h0000, 0, 8'h02, 32'd6);      // merge
        send_packet(16'hFFFF, 2, 8'h00, 32'hFFFFFFFF); // empty mask
        send_beat(mk(OpUnused, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF)); // ignored
        send_beat(mk(OpClaim, 16'd0, 8'd0, 8'hFF, 32'hFFFFFFFF));
        send_beat(mk(OpClaim, 16'd0, 8'd0, 8'h80, 32'd40000)); // expiry of older entries
        send_packet(16'h1234, 1, 8'hFF, 32'd40001);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(RegMaxEntries, 32'd0);           // refuse all new
        write_reg(RegWindow, 32'hFFFFFFFF);
        send_packet(16'h0007, 1, 8'h10, 32'd100);
        drain();
        write_reg(RegMaxEntries, 32'd31);          // above table depth
        write_reg(RegWindow, 32'd0);
        send_packet(16'h0008, 0, 8'h10, 32'd100);
        send_packet(16'h0008, 0, 8'h10, 32'd100);  // age 0, still alive
        send_packet(16'h0008, 0, 8'h10, 32'd101);  // expired
        drain();
    endtask

    // mostly well-formed packets drawing on a small fingerprint pool
    task automatic test_random(int npkts, logic [31:0] win, logic [4:0] lim);
        logic [31:0] clk_ms;
        write_reg(RegWindow, win);
        write_reg(RegMaxEntries, 32'(lim));
        clk_ms = $urandom;
        for (int p = 0; p < npkts; p++) begin
            clk_ms += $urandom_range(win > 1000 ? 800 : 40);
            if ($urandom_range(9) == 0) begin
                // noise: stray beats
                send_beat(mk(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                             $urandom));
            end else begin
                send_packet($urandom_range(1) ? 16'($urandom_range(12)) : 16'($urandom),
                            $urandom_range(2),
                            $urandom_range(4) == 0 ? 8'($urandom) : 8'(1 << $urandom_range(7)),
                            clk_ms);
            end
            if (p == npkts / 2) drain();   // sender holds off until all results are in
        end
        drain();
    endtask

    initial begin
        win_ms = 32'd30000;
        max_ent = 5'd16;
        fp_hash = FnvBasis;
        tab_cnt = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        send_idle_pct = 33; recv_idle_pct = 82;
        test_random(80, 32'd30000, 5'd16);
        test_random(50, 32'd200, 5'd3);
        send_idle_pct = 82; recv_idle_pct = 33;
        test_random(80, 32'd2000, 5'd16);
        test_random(40, 32'd0, 5'd1);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(80, 32'hFFFFFFFF, 5'd8);
        test_random(50, 32'd50, 5'd16);
        if (n_errors == 0 && verdicts_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
design/pdf_pkg.sv
design/pdf_datapath.sv
design/pdf_ctrl.sv
design/packet_duplicate_filter.sv
tb/sv/packet_duplicate_filter_tb.sv
